// File: hdl/tic_pkg.sv
`default_nettype none

package tic_pkg;

    localparam int unsigned InstrWidth = 16;
    localparam int unsigned ClassWidth = 7;

    typedef enum logic [ClassWidth-1:0] {
        CLS_UNDEF = 7'd0,
        CLS_LSL1, CLS_LSR1, CLS_ASR1, CLS_ADD1, CLS_ADD3, CLS_SUB1, CLS_SUB3, CLS_MOV2,
        CLS_ADD2, CLS_CMP1, CLS_MOV1, CLS_SUB2,
        CLS_LDR3, CLS_STR2, CLS_STRH2, CLS_STRB2, CLS_LDRSB, CLS_LDR2, CLS_LDRH2,
        CLS_LDRB2, CLS_LDRSH, CLS_ADC, CLS_ADD4, CLS_AND, CLS_ASR2, CLS_BIC, CLS_BLX2,
        CLS_BX, CLS_CMN, CLS_CMP2, CLS_CMP3, CLS_EOR, CLS_LSL2, CLS_LSR2, CLS_MOV3,
        CLS_MUL, CLS_MVN, CLS_NEG, CLS_ORR, CLS_ROR, CLS_SBC, CLS_TST,
        CLS_STR1 = 7'd43, CLS_LDR1, CLS_STRB1, CLS_LDRB1,
        CLS_STRH1, CLS_LDRH1, CLS_STR3, CLS_LDR4,
        CLS_ADD5 = 7'd51, CLS_ADD6, CLS_ADD7, CLS_SUB4, CLS_PUSH, CLS_BKPT, CLS_POP,
        CLS_STMIA, CLS_LDMIA, CLS_SWI, CLS_B1, CLS_B2, CLS_BLX1,
        CLS_BL = 7'd64
    } t_class_id;

    typedef logic [InstrWidth-1:0] t_instr;

    typedef struct packed {
        t_class_id class_id;
        logic      is_undefined;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/tic_if.sv
`default_nettype none

interface tic_in_if;
    logic            valid;
    logic            ready;
    tic_pkg::t_instr instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface tic_out_if;
    logic                             valid;
    logic                             ready;
    logic [tic_pkg::ClassWidth-1:0]   class_id;
    logic                             is_undefined;

    modport source (output valid, output class_id, output is_undefined, input ready);
    modport sink   (input valid, input class_id, input is_undefined, output ready);
endinterface

`default_nettype wire

// File: hdl/tic_decode.sv
`default_nettype none

module tic_decode (
    input  tic_pkg::t_instr  i_instr,
    output tic_pkg::t_result o_result
);

    tic_pkg::t_class_id w_cls;
    logic [2:0]         w_top;
    logic [1:0]         w_op;

    assign w_top = i_instr[15:13];
    assign w_op  = i_instr[12:11];

    always_comb begin
        w_cls = tic_pkg::CLS_UNDEF;
        unique case (w_top)
            3'd0: begin
                unique case (w_op)
                    2'd0: w_cls = tic_pkg::CLS_LSL1;
                    2'd1: w_cls = tic_pkg::CLS_LSR1;
                    2'd2: w_cls = tic_pkg::CLS_ASR1;
                    default: begin
                        // ADD1 wins over MOV2
                        unique case (i_instr[10:9])
                            2'b10:   w_cls = tic_pkg::CLS_ADD1;
                            2'b00:   w_cls = tic_pkg::CLS_ADD3;
                            2'b11:   w_cls = tic_pkg::CLS_SUB1;
                            default: w_cls = tic_pkg::CLS_SUB3;
                        endcase
                    end
                endcase
            end
            3'd1: begin
                unique case (w_op)
                    2'd0:    w_cls = tic_pkg::CLS_MOV1;
                    2'd1:    w_cls = tic_pkg::CLS_CMP1;
                    2'd2:    w_cls = tic_pkg::CLS_ADD2;
                    default: w_cls = tic_pkg::CLS_SUB2;
                endcase
            end
            3'd2: begin
                if (w_op == 2'd1) begin
                    w_cls = tic_pkg::CLS_LDR3;
                end else if (w_op[1]) begin
                    unique case (i_instr[11:9])
                        3'd0:    w_cls = tic_pkg::CLS_STR2;
                        3'd1:    w_cls = tic_pkg::CLS_STRH2;
                        3'd2:    w_cls = tic_pkg::CLS_STRB2;
                        3'd3:    w_cls = tic_pkg::CLS_LDRSB;
                        3'd4:    w_cls = tic_pkg::CLS_LDR2;
                        3'd5:    w_cls = tic_pkg::CLS_LDRH2;
                        3'd6:    w_cls = tic_pkg::CLS_LDRB2;
                        default: w_cls = tic_pkg::CLS_LDRSH;
                    endcase
                end else begin
                    unique case (i_instr[10:6])
                        5'd0:  w_cls = tic_pkg::CLS_AND;
                        5'd1:  w_cls = tic_pkg::CLS_EOR;
                        5'd2:  w_cls = tic_pkg::CLS_LSL2;
                        5'd3:  w_cls = tic_pkg::CLS_LSR2;
                        5'd4:  w_cls = tic_pkg::CLS_ASR2;
                        5'd5:  w_cls = tic_pkg::CLS_ADC;
                        5'd6:  w_cls = tic_pkg::CLS_SBC;
                        5'd7:  w_cls = tic_pkg::CLS_ROR;
                        5'd8:  w_cls = tic_pkg::CLS_TST;
                        5'd9:  w_cls = tic_pkg::CLS_NEG;
                        5'd10: w_cls = tic_pkg::CLS_CMP2;
                        5'd11: w_cls = tic_pkg::CLS_CMN;
                        5'd12: w_cls = tic_pkg::CLS_ORR;
                        5'd13: w_cls = tic_pkg::CLS_MUL;
                        5'd14: w_cls = tic_pkg::CLS_BIC;
                        5'd15: w_cls = tic_pkg::CLS_MVN;
                        5'd16, 5'd17, 5'd18, 5'd19: w_cls = tic_pkg::CLS_ADD4;
                        5'd20, 5'd21, 5'd22, 5'd23: w_cls = tic_pkg::CLS_CMP3;
                        5'd24, 5'd25, 5'd26, 5'd27: w_cls = tic_pkg::CLS_MOV3;
                        5'd28, 5'd29: w_cls = tic_pkg::CLS_BX;
                        default:      w_cls = tic_pkg::CLS_BLX2;
                    endcase
                end
            end
            3'd3: begin
                unique case (w_op)
                    2'd0:    w_cls = tic_pkg::CLS_STR1;
                    2'd1:    w_cls = tic_pkg::CLS_LDR1;
                    2'd2:    w_cls = tic_pkg::CLS_STRB1;
                    default: w_cls = tic_pkg::CLS_LDRB1;
                endcase
            end
            3'd4: begin
                unique case (w_op)
                    2'd0:    w_cls = tic_pkg::CLS_STRH1;
                    2'd1:    w_cls = tic_pkg::CLS_LDRH1;
                    2'd2:    w_cls = tic_pkg::CLS_STR3;
                    default: w_cls = tic_pkg::CLS_LDR4;
                endcase
            end
            3'd5: begin
                unique case (w_op)
                    2'd0: w_cls = tic_pkg::CLS_ADD5;
                    2'd1: w_cls = tic_pkg::CLS_ADD6;
                    2'd2: begin
                        if (i_instr[10:7] == 4'd0) begin
                            w_cls = tic_pkg::CLS_ADD7;
                        end else if (i_instr[10:7] == 4'd1) begin
                            w_cls = tic_pkg::CLS_SUB4;
                        end else if (i_instr[10:9] == 2'b10) begin
                            w_cls = tic_pkg::CLS_PUSH;
                        end else begin
                            w_cls = tic_pkg::CLS_UNDEF;
                        end
                    end
                    default: begin
                        if (i_instr[10:8] == 3'b110) begin
                            w_cls = tic_pkg::CLS_BKPT;
                        end else if (i_instr[10:9] == 2'b10) begin
                            w_cls = tic_pkg::CLS_POP;
                        end else begin
                            w_cls = tic_pkg::CLS_UNDEF;
                        end
                    end
                endcase
            end
            3'd6: begin
                if (w_op == 2'd0) begin
                    w_cls = tic_pkg::CLS_STMIA;
                end else if (w_op == 2'd1) begin
                    w_cls = tic_pkg::CLS_LDMIA;
                end else if (i_instr[12:8] == 5'h1F) begin
                    w_cls = tic_pkg::CLS_SWI;
                end else begin
                    w_cls = tic_pkg::CLS_B1;
                end
            end
            default: begin
                unique case (w_op)
                    2'd0:    w_cls = tic_pkg::CLS_B2;
                    2'd1:    w_cls = tic_pkg::CLS_BLX1;
                    default: w_cls = tic_pkg::CLS_BL;
                endcase
            end
        endcase
    end

    assign o_result.class_id     = w_cls;
    assign o_result.is_undefined = (w_cls == tic_pkg::CLS_UNDEF);

endmodule

`default_nettype wire

// File: hdl/thumb_instruction_classifier.sv
`default_nettype none

// Channel  Dir  Port   Beat fields
// -------  ---  -----  -----------------------------
// in       in   i_in   instruction[15:0]
// out      out  o_out  class_id[6:0], is_undefined
//
// Two register stages: instruction register, decode, result register.
// One beat per cycle sustained while the output is not stalled; the decode is a single
// combinational pass between the two registers.
// Synchronous active-low reset empties both stages.
// A stalled output holds its beat; the input stage keeps taking beats
// until both stages are full.

module thumb_instruction_classifier (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tic_in_if.sink       i_in,
    tic_out_if.source    o_out
);

    logic               r_s1_valid;
    logic               n_s1_valid;
    tic_pkg::t_instr    r_instr;
    logic               r_s2_valid;
    logic               n_s2_valid;
    tic_pkg::t_result   r_res;
    tic_pkg::t_result   w_dec;
    logic               w_s1_adv;
    logic               w_in_ready;

    tic_decode u_decode (
        .i_instr  (r_instr),
        .o_result (w_dec)
    );

    assign w_s1_adv   = !r_s2_valid || o_out.ready;
    assign w_in_ready = !r_s1_valid || w_s1_adv;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s2_valid = r_s2_valid;
        if (w_in_ready) begin
            n_s1_valid = i_in.valid;
        end
        if (w_s1_adv) begin
            n_s2_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_instr <= i_in.instruction;
        end
        if (w_s1_adv && r_s1_valid) begin
            r_res <= w_dec;
        end
    end

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_s2_valid;
    assign o_out.class_id     = r_res.class_id;
    assign o_out.is_undefined = r_res.is_undefined;

endmodule

`default_nettype wire

// File: hdl/tic_checker.sv
`default_nettype none

module tic_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             i_in_ready,
    input wire                             i_out_valid,
    input wire                             i_out_ready,
    input wire [tic_pkg::ClassWidth-1:0]   i_class_id,
    input wire                             i_is_undefined
);

    a_undef_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_undefined == (i_class_id == tic_pkg::CLS_UNDEF)))
        else $error("is_undefined disagrees with class_id");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_class_id <= tic_pkg::CLS_BL && i_class_id != tic_pkg::CLS_MOV2))
        else $error("class_id out of range or shadowed class produced");

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output side is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_class_id) && $stable(i_is_undefined)))
        else $error("stalled output beat changed");

    a_in_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_ready) |-> i_out_valid)
        else $error("input refused with output stage empty");

endmodule

bind thumb_instruction_classifier tic_checker u_tic_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_class_id     (o_out.class_id),
    .i_is_undefined (o_out.is_undefined)
);

`default_nettype wire
